// ===== rtl/ordered_array_list_macros.svh =====
// Assertion macros for the ordered array list.
// Included by the top level; no other dependencies.
`ifndef ORDERED_ARRAY_LIST_MACROS_SVH
`define ORDERED_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ordered_array_list: assertion failed");

// Next-cycle implication, disabled during reset.
`define OAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ordered_array_list: assertion failed");

`endif

// ===== rtl/ordl_pkg.sv =====
// Shared types and constants for the ordered array list.
// No dependencies.
package ordl_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int CMD_W        = 3;
	localparam int POS_W        = 7;
	localparam int VAL_W        = 32;
	localparam int STAT_W       = 2;
	localparam int CNT_W        = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_POP_BACK   = 3'd1,
		CMD_PUSH_FRONT = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_INSERT     = 3'd4,
		CMD_ERASE      = 3'd5,
		CMD_READ       = 3'd6
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Broadcast to every cell in the chain.
	typedef struct packed {
		logic open_gap;
		logic close_gap;
	} cell_ctl_t;

endpackage

// ===== rtl/ordl_cell.sv =====
// One storage cell of the ordered array list chain.
// Depends on ordl_pkg; instantiated by ordered_array_list.
module ordl_cell
	import ordl_pkg::*;
#(
	parameter int PW  = 7,
	parameter int IDX = 0
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [PW-1:0]    gap_pos,
	input  logic [VAL_W-1:0] value,
	input  logic [VAL_W-1:0] left_data,
	input  logic [VAL_W-1:0] right_data,
	output logic [VAL_W-1:0] data_q
);

	localparam logic [PW-1:0] IDX_P = PW'(IDX);

	always_ff @(posedge clk) begin
		if (ctl.open_gap) begin
			if (IDX_P == gap_pos) begin
				data_q <= value;
			end else if (IDX_P > gap_pos) begin
				data_q <= left_data;
			end
		end else if (ctl.close_gap) begin
			if (IDX_P >= gap_pos) begin
				data_q <= right_data;
			end
		end
	end

endmodule

// ===== rtl/ordered_array_list.sv =====
// Ordered list of signed 32-bit values held in a chain of CAPACITY cells.
// Depends on ordl_pkg, ordl_cell and ordered_array_list_macros.svh.
//
// Input channel (in_valid / in_stall) carries one command transaction:
// command, position and value. Output channel (out_valid / out_stall)
// returns one transaction per command: status, count after the command,
// and read_value (the element for a successful read, zero otherwise).
// The result is registered at the edge that accepts the command. One
// command is taken per cycle while in_stall is low; insert and erase shift
// all cells at once, so the position does not change how long a command takes.
// A failing command (full, empty, bad position) changes nothing.
// While out_valid is high and out_stall is asserted the result holds and
// in_stall is raised; a new command is taken in the same cycle the held
// result is drained.
// Reset (arst_n low) empties the list and clears out_valid. Cell contents
// are not cleared; only cells below the count are ever read.
`include "ordered_array_list_macros.svh"

module ordered_array_list
	import ordl_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic [POS_W-1:0]  position,
	input  logic [VAL_W-1:0]  value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic [CNT_W-1:0]  count,
	output logic [VAL_W-1:0]  read_value
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int EW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    cnt_n;
	logic [EW-1:0]    cnt_e;
	logic [EW-1:0]    pos_e;
	logic             full;
	logic             empty;
	logic             in_acc;
	status_t          st_n;
	logic [VAL_W-1:0] rd_n;
	logic [CW-1:0]    gap_pos;
	cell_ctl_t        op_n;
	cell_ctl_t        ctl;

	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [CNT_W-1:0]  count_q;
	logic [VAL_W-1:0]  read_value_q;

	logic [VAL_W-1:0] cell_data [CAPACITY];

	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;

	assign cnt_e = EW'(cnt_q);
	assign pos_e = EW'(position);
	assign full  = (cnt_q == CW'(CAPACITY));
	assign empty = (cnt_q == '0);

	always_comb begin
		st_n    = ST_OK;
		rd_n    = '0;
		cnt_n   = cnt_q;
		gap_pos = '0;
		op_n    = '0;
		case (cmd_t'(command))
			CMD_PUSH_BACK: begin
				if (full) begin
					st_n = ST_FULL;
				end else begin
					op_n.open_gap = 1'b1;
					gap_pos       = cnt_q;
					cnt_n         = cnt_q + CW'(1);
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					st_n = ST_EMPTY;
				end else begin
					cnt_n = cnt_q - CW'(1);
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					st_n = ST_FULL;
				end else begin
					op_n.open_gap = 1'b1;
					cnt_n         = cnt_q + CW'(1);
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					st_n = ST_EMPTY;
				end else begin
					op_n.close_gap = 1'b1;
					cnt_n          = cnt_q - CW'(1);
				end
			end
			CMD_INSERT: begin
				if (pos_e > cnt_e) begin
					st_n = ST_RANGE;
				end else if (full) begin
					st_n = ST_FULL;
				end else begin
					op_n.open_gap = 1'b1;
					gap_pos       = pos_e[CW-1:0];
					cnt_n         = cnt_q + CW'(1);
				end
			end
			CMD_ERASE: begin
				if (empty) begin
					st_n = ST_EMPTY;
				end else if (pos_e >= cnt_e) begin
					st_n = ST_RANGE;
				end else begin
					op_n.close_gap = 1'b1;
					gap_pos        = pos_e[CW-1:0];
					cnt_n          = cnt_q - CW'(1);
				end
			end
			CMD_READ: begin
				if (empty) begin
					st_n = ST_EMPTY;
				end else if (pos_e >= cnt_e) begin
					st_n = ST_RANGE;
				end else begin
					rd_n = cell_data[pos_e[IW-1:0]];
				end
			end
			default: begin
			end
		endcase
	end

	assign ctl.open_gap  = in_acc & op_n.open_gap;
	assign ctl.close_gap = in_acc & op_n.close_gap;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left_d;
		logic [VAL_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		ordl_cell #(
			.PW  (CW),
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.gap_pos    (gap_pos),
			.value      (value),
			.left_data  (left_d),
			.right_data (right_d),
			.data_q     (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				cnt_q       <= cnt_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q     <= st_n;
			count_q      <= CNT_W'(cnt_n);
			read_value_q <= rd_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign count      = count_q;
	assign read_value = read_value_q;

	`OAL_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY))
	`OAL_ASSERT_NOW(a_stall_only_held, clk, arst_n, in_stall, out_valid_q)
	`OAL_ASSERT_NEXT(a_fail_keeps_cnt, clk, arst_n, in_acc && st_n != ST_OK,
		cnt_q == $past(cnt_q))
	`OAL_ASSERT_NEXT(a_count_matches, clk, arst_n, in_acc, count_q == CNT_W'(cnt_q))

endmodule
